/* rtl/hmtri_pkg.sv */
`default_nettype none

package hmtri_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int MAX_HEIGHT_DEFAULT = 1024;

    localparam int SAMPLE_W   = 8;
    localparam int COORD_W    = 10;
    localparam int Z_W        = 11;
    localparam int ZOFF_W     = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int SLOT_COUNT = 12;
    localparam int TRI_W      = 3 * (2 * COORD_W + Z_W);
    localparam int TDATA_OUT_W = ((TRI_W + 7) / 8) * 8;

    localparam logic [ZOFF_W-1:0] ZOFF_RESET = ZOFF_W'(30);

    // Register indexes of the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RASTER_WIDTH  = 2'd0,
        CFG_RASTER_HEIGHT = 2'd1,
        CFG_Z_OFFSET      = 2'd2
    } cfg_idx_e;

    // Triangle slots of one pixel, in emission order.
    typedef enum logic [3:0] {
        SLOT_SURF0  = 4'd0,
        SLOT_SURF1  = 4'd1,
        SLOT_TOP0   = 4'd2,
        SLOT_TOP1   = 4'd3,
        SLOT_BOT0   = 4'd4,
        SLOT_BOT1   = 4'd5,
        SLOT_LEFT0  = 4'd6,
        SLOT_LEFT1  = 4'd7,
        SLOT_RIGHT0 = 4'd8,
        SLOT_RIGHT1 = 4'd9,
        SLOT_BASE0  = 4'd10,
        SLOT_BASE1  = 4'd11
    } slot_e;

    typedef struct packed {
        logic [Z_W-1:0]     z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } vertex_t;

    typedef struct packed {
        vertex_t v2;
        vertex_t v1;
        vertex_t v0;
    } tri_t;

    // Everything the triangle builder needs to know about one pixel.
    typedef struct packed {
        logic [SAMPLE_W-1:0] cur;
        logic [SAMPLE_W-1:0] up;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] up_left;
        logic [ZOFF_W-1:0]   zoff;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
    } pix_t;

    // Lowest pending slot of a pixel.
    function automatic slot_e first_slot(input logic [SLOT_COUNT-1:0] mask);
        slot_e s;
        s = SLOT_SURF0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (mask[i]) begin
                s = slot_e'(i);
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/heightmap_mesh_triangulator_core.sv */
`default_nettype none

// Channel     | Direction | Signals                          | Contents
// ------------+-----------+----------------------------------+---------------------------
// s_axis      | in        | tvalid, tready, tdata[7:0]       | height_sample
// m_axis      | out       | tvalid, tready, tdata[95:0]      | one triangle (three vertices)
//             |           | tlast                            | run_end, last triangle of pixel
// cfg         | in        | valid, ready, index[1:0], data   | register write
//
// A pixel stays in the pixel stage until its triangles are emitted, and retires
// without emitting if it causes none: an interior pixel causes two triangles,
// the last pixel eight. The single output register takes one triangle per cycle
// while the output is not stalled. The previous row lives in a synchronous RAM
// read when the pixel is accepted. Reset clears the raster position, the
// neighbor registers and the handshake state; the row RAM is not cleared, since
// every entry is written in a frame before its data is used. A stalled output
// holds its transaction and, once the pixel stage is full, stalls the input.

module heightmap_mesh_triangulator_core #(
    parameter int MAX_WIDTH  = hmtri_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = hmtri_pkg::MAX_HEIGHT_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [7:0] height_sample
    input  wire logic [hmtri_pkg::SAMPLE_W-1:0]       s_axis_tdata,

    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [9:0] first_x, [19:10] first_y, [30:20] first_z, [40:31] second_x,
    // [50:41] second_y, [61:51] second_z, [71:62] third_x, [81:72] third_y,
    // [92:82] third_z, [95:93] zero
    output logic [hmtri_pkg::TDATA_OUT_W-1:0]         m_axis_tdata,
    output logic                                      m_axis_tlast,

    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [hmtri_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hmtri_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int SW = hmtri_pkg::SAMPLE_W;
    localparam int NS = hmtri_pkg::SLOT_COUNT;

    // Raster geometry: last column and last row, already saturated.
    logic [CW-1:0]                 right_reg, right_next;
    logic [RW-1:0]                 bot_reg, bot_next;
    logic [hmtri_pkg::ZOFF_W-1:0]  zoff_reg;
    logic [CW:0]                   w_eff;
    logic [RW:0]                   h_eff;
    logic                          cfg_write;
    logic                          geom_write;

    // Position of the next pixel to arrive.
    logic [CW-1:0]                 col_reg, col_next;
    logic [RW-1:0]                 row_reg, row_next;

    // Pixel stage: the pixel whose triangles are being emitted.
    logic                          s1_valid_reg;
    logic [SW-1:0]                 s1_cur_reg;
    logic [CW-1:0]                 s1_col_reg;
    logic [RW-1:0]                 s1_row_reg;
    logic [NS-1:0]                 s1_mask_reg, s1_mask_next;
    logic [NS-1:0]                 mask_new;
    logic [NS-1:0]                 mask_rest;

    logic [SW-1:0]                 left_reg;
    logic [SW-1:0]                 up_left_reg;
    logic [SW-1:0]                 up_data;

    logic                          out_valid_reg;
    hmtri_pkg::tri_t               out_tri_reg;
    logic                          out_last_reg;

    logic                          accept;
    logic                          out_free;
    logic                          emit;
    logic                          retire;
    hmtri_pkg::pix_t               pix;
    hmtri_pkg::slot_e              slot;
    hmtri_pkg::tri_t               tri_cur;

    logic                          c_first, c_last, r_first, r_last;

    // ------------------------------------------------------------------
    // Configuration. Writes are accepted at once; a size write restarts
    // the frame.
    // ------------------------------------------------------------------
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign geom_write = cfg_write &&
                        ((cfg_index == hmtri_pkg::CFG_RASTER_WIDTH) ||
                         (cfg_index == hmtri_pkg::CFG_RASTER_HEIGHT));

    always_comb
    begin
        if (cfg_data < hmtri_pkg::CFG_DATA_W'(2)) begin
            w_eff = (CW+1)'(2);
            h_eff = (RW+1)'(2);
        end else begin
            w_eff = (32'(cfg_data) > 32'(MAX_WIDTH)) ? (CW+1)'(MAX_WIDTH)
                                                     : (CW+1)'(cfg_data);
            h_eff = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? (RW+1)'(MAX_HEIGHT)
                                                      : (RW+1)'(cfg_data);
        end
        right_next = right_reg;
        bot_next   = bot_reg;
        if (cfg_write) begin
            case (cfg_index)
                hmtri_pkg::CFG_RASTER_WIDTH:  right_next = CW'(w_eff - 1'b1);
                hmtri_pkg::CFG_RASTER_HEIGHT: bot_next   = RW'(h_eff - 1'b1);
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            right_reg <= CW'(1);
            bot_reg   <= RW'(1);
            zoff_reg  <= hmtri_pkg::ZOFF_RESET;
        end else begin
            right_reg <= right_next;
            bot_reg   <= bot_next;
            if (cfg_write && (cfg_index == hmtri_pkg::CFG_Z_OFFSET)) begin
                zoff_reg <= cfg_data[hmtri_pkg::ZOFF_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The pixel stage frees up in the cycle its last triangle
    // moves into the output register, so the next pixel enters right away.
    // ------------------------------------------------------------------
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign mask_rest     = s1_mask_reg & (s1_mask_reg - 1'b1);
    assign emit          = s1_valid_reg && (s1_mask_reg != '0) && out_free;
    assign retire        = s1_valid_reg &&
                           ((s1_mask_reg == '0) || (emit && (mask_rest == '0)));
    assign s_axis_tready = !s1_valid_reg || retire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Raster position and the set of triangles an arriving pixel causes.
    // ------------------------------------------------------------------
    assign c_first = (col_reg == '0);
    assign c_last  = (col_reg == right_reg);
    assign r_first = (row_reg == '0);
    assign r_last  = (row_reg == bot_reg);

    always_comb
    begin
        mask_new = '0;
        mask_new[hmtri_pkg::SLOT_SURF0]  = !r_first && !c_first;
        mask_new[hmtri_pkg::SLOT_SURF1]  = !r_first && !c_first;
        mask_new[hmtri_pkg::SLOT_TOP0]   = r_first && !c_first;
        mask_new[hmtri_pkg::SLOT_TOP1]   = r_first && !c_first;
        mask_new[hmtri_pkg::SLOT_BOT0]   = r_last && !c_first;
        mask_new[hmtri_pkg::SLOT_BOT1]   = r_last && !c_first;
        mask_new[hmtri_pkg::SLOT_LEFT0]  = c_first && !r_first;
        mask_new[hmtri_pkg::SLOT_LEFT1]  = c_first && !r_first;
        mask_new[hmtri_pkg::SLOT_RIGHT0] = c_last && !r_first;
        mask_new[hmtri_pkg::SLOT_RIGHT1] = c_last && !r_first;
        mask_new[hmtri_pkg::SLOT_BASE0]  = c_last && r_last;
        mask_new[hmtri_pkg::SLOT_BASE1]  = c_last && r_last;

        col_next = col_reg;
        row_next = row_reg;
        if (geom_write) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_reg >= right_reg) begin
                col_next = '0;
                row_next = (row_reg >= bot_reg) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end

        s1_mask_next = s1_mask_reg;
        if (accept) begin
            s1_mask_next = mask_new;
        end else if (emit) begin
            s1_mask_next = mask_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_mask_reg  <= '0;
            left_reg     <= '0;
            up_left_reg  <= '0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            s1_mask_reg <= s1_mask_next;
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (retire) begin
                s1_valid_reg <= 1'b0;
            end
            // The neighbors move on when a pixel leaves the stage.
            if (retire) begin
                left_reg    <= s1_cur_reg;
                up_left_reg <= up_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_cur_reg <= s_axis_tdata;
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
        end
    end

    // ------------------------------------------------------------------
    // Previous-row store. Read and written at the arriving pixel's column
    // in the same cycle; the read returns the row above, the write leaves
    // this row for the next one. The read data holds while the pixel waits.
    // ------------------------------------------------------------------
    hmtri_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (s_axis_tdata),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (up_data)
    );

    // ------------------------------------------------------------------
    // Triangle builder and output register.
    // ------------------------------------------------------------------
    assign slot = hmtri_pkg::first_slot(s1_mask_reg);

    assign pix = '{cur:     s1_cur_reg,
                   up:      up_data,
                   left:    left_reg,
                   up_left: up_left_reg,
                   zoff:    zoff_reg,
                   x:       hmtri_pkg::COORD_W'(s1_col_reg),
                   y:       hmtri_pkg::COORD_W'(s1_row_reg)};

    hmtri_vertex u_vertex (
        .pix     (pix),
        .slot    (slot),
        .tri_out (tri_cur)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            out_tri_reg  <= tri_cur;
            out_last_reg <= (mask_rest == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = hmtri_pkg::TDATA_OUT_W'(out_tri_reg);

endmodule

`default_nettype wire

/* rtl/hmtri_ram.sv */
`default_nettype none

module hmtri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/hmtri_vertex.sv */
`default_nettype none

module hmtri_vertex (
    input  wire hmtri_pkg::pix_t  pix,
    input  wire hmtri_pkg::slot_e slot,
    output hmtri_pkg::tri_t       tri_out
);

    logic [hmtri_pkg::COORD_W-1:0] x;
    logic [hmtri_pkg::COORD_W-1:0] y;
    logic [hmtri_pkg::COORD_W-1:0] xm1;
    logic [hmtri_pkg::COORD_W-1:0] ym1;
    logic [hmtri_pkg::Z_W-1:0]     zc;
    logic [hmtri_pkg::Z_W-1:0]     zu;
    logic [hmtri_pkg::Z_W-1:0]     zl;
    logic [hmtri_pkg::Z_W-1:0]     zul;
    logic [hmtri_pkg::Z_W-1:0]     z0;
    logic [hmtri_pkg::COORD_W-1:0] c0;

    assign x   = pix.x;
    assign y   = pix.y;
    assign xm1 = x - hmtri_pkg::COORD_W'(1);
    assign ym1 = y - hmtri_pkg::COORD_W'(1);
    assign zc  = hmtri_pkg::Z_W'(pix.cur) + hmtri_pkg::Z_W'(pix.zoff);
    assign zu  = hmtri_pkg::Z_W'(pix.up) + hmtri_pkg::Z_W'(pix.zoff);
    assign zl  = hmtri_pkg::Z_W'(pix.left) + hmtri_pkg::Z_W'(pix.zoff);
    assign zul = hmtri_pkg::Z_W'(pix.up_left) + hmtri_pkg::Z_W'(pix.zoff);
    assign z0  = '0;
    assign c0  = '0;

    // Wall and base slots only occur on the edge they belong to, so the
    // pixel's own row or column is the bottom row or right column there.
    always_comb
    begin
        case (slot)
            hmtri_pkg::SLOT_SURF0: tri_out = '{v0: '{x: xm1, y: ym1, z: zul},
                                               v1: '{x: x,   y: ym1, z: zu},
                                               v2: '{x: xm1, y: y,   z: zl}};
            hmtri_pkg::SLOT_SURF1: tri_out = '{v0: '{x: xm1, y: y,   z: zl},
                                               v1: '{x: x,   y: ym1, z: zu},
                                               v2: '{x: x,   y: y,   z: zc}};
            hmtri_pkg::SLOT_TOP0:  tri_out = '{v0: '{x: xm1, y: c0,  z: zl},
                                               v1: '{x: xm1, y: c0,  z: z0},
                                               v2: '{x: x,   y: c0,  z: zc}};
            hmtri_pkg::SLOT_TOP1:  tri_out = '{v0: '{x: x,   y: c0,  z: zc},
                                               v1: '{x: xm1, y: c0,  z: z0},
                                               v2: '{x: x,   y: c0,  z: z0}};
            hmtri_pkg::SLOT_BOT0:  tri_out = '{v0: '{x: xm1, y: y,   z: zl},
                                               v1: '{x: x,   y: y,   z: zc},
                                               v2: '{x: xm1, y: y,   z: z0}};
            hmtri_pkg::SLOT_BOT1:  tri_out = '{v0: '{x: xm1, y: y,   z: z0},
                                               v1: '{x: x,   y: y,   z: zc},
                                               v2: '{x: x,   y: y,   z: z0}};
            hmtri_pkg::SLOT_LEFT0: tri_out = '{v0: '{x: c0,  y: ym1, z: zu},
                                               v1: '{x: c0,  y: y,   z: zc},
                                               v2: '{x: c0,  y: ym1, z: z0}};
            hmtri_pkg::SLOT_LEFT1: tri_out = '{v0: '{x: c0,  y: ym1, z: z0},
                                               v1: '{x: c0,  y: y,   z: zc},
                                               v2: '{x: c0,  y: y,   z: z0}};
            hmtri_pkg::SLOT_RIGHT0: tri_out = '{v0: '{x: x,  y: ym1, z: zu},
                                                v1: '{x: x,  y: ym1, z: z0},
                                                v2: '{x: x,  y: y,   z: z0}};
            hmtri_pkg::SLOT_RIGHT1: tri_out = '{v0: '{x: x,  y: ym1, z: zu},
                                                v1: '{x: x,  y: y,   z: z0},
                                                v2: '{x: x,  y: y,   z: zc}};
            hmtri_pkg::SLOT_BASE0: tri_out = '{v0: '{x: c0,  y: c0,  z: z0},
                                               v1: '{x: c0,  y: y,   z: z0},
                                               v2: '{x: x,   y: c0,  z: z0}};
            hmtri_pkg::SLOT_BASE1: tri_out = '{v0: '{x: x,   y: c0,  z: z0},
                                               v1: '{x: c0,  y: y,   z: z0},
                                               v2: '{x: x,   y: y,   z: z0}};
            default:               tri_out = '0;
        endcase
    end

endmodule

`default_nettype wire
